FILE: rtl/core/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned CapacityDefault  = 1024;
  localparam int unsigned ValueBitsDefault = 31;

  localparam int unsigned OperandBits = 32;
  localparam int unsigned CountBits   = 11;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_BACK  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

FILE: rtl/core/rbd_ram.sv
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rbd_ctrl.sv
`timescale 1ns / 1ps

module rbd_ctrl #(
  parameter int unsigned Capacity  = rbd_pkg::CapacityDefault,
  parameter int unsigned ValueBits = rbd_pkg::ValueBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [1:0]                           command_i,
  input  logic [rbd_pkg::OperandBits-1:0]      operand_i,
  output logic [$clog2(Capacity)-1:0]          ram_addr_o,
  output logic                                 ram_we_o,
  output logic [ValueBits-1:0]                 ram_wdata_o,
  input  logic [ValueBits-1:0]                 ram_rdata_i,
  output logic                                 result_valid_o,
  output logic [rbd_pkg::OperandBits-1:0]      popped_value_o,
  output logic [1:0]                           status_o,
  output logic                                 expectation_met_o,
  output logic [rbd_pkg::CountBits-1:0]        entry_count_o
);

  import rbd_pkg::*;

  localparam int unsigned AddrBits = $clog2(Capacity);
  localparam int unsigned CntBits  = $clog2(Capacity + 1);

  localparam logic [AddrBits-1:0] LastSlot = AddrBits'(Capacity - 1);
  localparam logic [CntBits-1:0]  FullCnt  = CntBits'(Capacity);

  logic [AddrBits-1:0] front_q, front_d, back_q, back_d;
  logic [CntBits-1:0]  count_q, count_d;

  logic                   valid_q;
  logic                   read_q, read_d;
  status_e                status_q, status_d;
  logic [OperandBits-1:0] expect_q;
  logic [CntBits-1:0]     res_count_q;

  logic [AddrBits-1:0] front_inc, front_dec, back_inc, back_dec;
  logic                full, empty;
  command_e            cmd;

  logic [ValueBits+OperandBits-1:0] wdata_ext, rdata_ext;
  logic [CountBits+CntBits-1:0]     count_ext;
  logic [OperandBits-1:0]           stored_value;

  assign cmd       = command_e'(command_i);
  assign full      = (count_q == FullCnt);
  assign empty     = (count_q == '0);
  assign front_inc = (front_q == LastSlot) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastSlot : front_q - 1'b1;
  assign back_inc  = (back_q == LastSlot) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? LastSlot : back_q - 1'b1;

  // only the low ValueBits of the operand are kept
  assign wdata_ext   = {{ValueBits{1'b0}}, operand_i};
  assign ram_wdata_o = wdata_ext[ValueBits-1:0];

  always_comb begin
    front_d    = front_q;
    back_d     = back_q;
    count_d    = count_q;
    ram_addr_o = front_q;
    ram_we_o   = 1'b0;
    read_d     = 1'b0;
    status_d   = STATUS_DONE;
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          ram_addr_o = front_q;
          ram_we_o   = start_i;
          front_d    = front_inc;
          count_d    = count_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          ram_addr_o = back_dec;
          ram_we_o   = start_i;
          back_d     = back_dec;
          count_d    = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          ram_addr_o = front_dec;
          read_d     = 1'b1;
          front_d    = front_dec;
          count_d    = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          ram_addr_o = back_q;
          read_d     = 1'b1;
          back_d     = back_inc;
          count_d    = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
      if (start_i) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      read_q      <= read_d;
      status_q    <= status_d;
      expect_q    <= operand_i;
      res_count_q <= count_d;
    end
  end

  // RAM data shows up the cycle after the pop transaction
  assign rdata_ext    = {{OperandBits{1'b0}}, ram_rdata_i};
  assign stored_value = rdata_ext[OperandBits-1:0];
  assign count_ext    = {{CountBits{1'b0}}, res_count_q};

  always_comb begin
    if (read_q) begin
      popped_value_o = stored_value;
    end else if (status_q == STATUS_EMPTY) begin
      popped_value_o = '1;
    end else begin
      popped_value_o = '0;
    end
  end

  assign expectation_met_o = (read_q || status_q == STATUS_EMPTY) ?
                             (popped_value_o == expect_q) : 1'b1;
  assign result_valid_o    = valid_q;
  assign status_o          = status_q;
  assign entry_count_o     = count_ext[CountBits-1:0];

endmodule

FILE: rtl/core/ring_buffer_deque.sv
`timescale 1ns / 1ps

// Double-ended queue in a circular store of Capacity entries.
// Command channel: command_i (push front, pop front, push back, pop back)
// and operand_i are taken at a rising edge where start_i is high and busy_o
// is low. busy_o is always low, so a command can be issued every cycle.
// Result channel: exactly one result per command, shown for one cycle with
// result_valid_o high, in the cycle after the command was taken. The receiver
// cannot stall; results must be captured when result_valid_o is high.
// Throughput: one command per cycle; the result timing is set by the registered
// read of the single-port element RAM. Each command touches at
// most one RAM entry, so no two accesses ever collide in the same cycle.
// A pop returns the stored value zero-extended, or all ones when empty;
// a push into a full store is refused and flagged in status_o.
// Reset: empties the deque and zeroes both positions; RAM contents are not
// cleared, since an entry is read only after it has been written.
module ring_buffer_deque #(
  parameter int unsigned Capacity  = rbd_pkg::CapacityDefault,
  parameter int unsigned ValueBits = rbd_pkg::ValueBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       command_i,
  input  logic [rbd_pkg::OperandBits-1:0]  operand_i,
  output logic                             result_valid_o,
  output logic [rbd_pkg::OperandBits-1:0]  popped_value_o,
  output logic [1:0]                       status_o,
  output logic                             expectation_met_o,
  output logic [rbd_pkg::CountBits-1:0]    entry_count_o
);

  import rbd_pkg::*;

  localparam int unsigned AddrBits = $clog2(Capacity);

  logic [AddrBits-1:0]  ram_addr;
  logic                 ram_we;
  logic [ValueBits-1:0] ram_wdata, ram_rdata;

  assign busy_o = 1'b0;

  rbd_ctrl #(
    .Capacity  (Capacity),
    .ValueBits (ValueBits)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .command_i         (command_i),
    .operand_i         (operand_i),
    .ram_addr_o        (ram_addr),
    .ram_we_o          (ram_we),
    .ram_wdata_o       (ram_wdata),
    .ram_rdata_i       (ram_rdata),
    .result_valid_o    (result_valid_o),
    .popped_value_o    (popped_value_o),
    .status_o          (status_o),
    .expectation_met_o (expectation_met_o),
    .entry_count_o     (entry_count_o)
  );

  rbd_ram #(
    .Width (ValueBits),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: test/tb_ring_buffer_deque.sv
`timescale 1ns / 1ps

module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned ValueBits  = ValueBitsDefault;
  localparam int unsigned CycleLimit = 300000;
  localparam logic [OperandBits-1:0] EmptyMark = '1;
  localparam logic [OperandBits-1:0] MaxValue  = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [OperandBits-1:0] value;
    status_e                status;
    logic                   met;
    logic [CountBits-1:0]   count;
  } outcome_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [1:0]             command_i;
  logic [OperandBits-1:0] operand_i;
  logic                   result_valid_o;
  logic [OperandBits-1:0] popped_value_o;
  logic [1:0]             status_o;
  logic                   expectation_met_o;
  logic [CountBits-1:0]   entry_count_o;

  // Shadow deque
  logic [ValueBits-1:0] store_mem [Capacity];
  int unsigned          front_pos;
  int unsigned          back_pos;
  int unsigned          held;

  outcome_t    pending_outcomes[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  bit          gaps_on;

  ring_buffer_deque u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .operand_i        (operand_i),
    .result_valid_o   (result_valid_o),
    .popped_value_o   (popped_value_o),
    .status_o         (status_o),
    .expectation_met_o(expectation_met_o),
    .entry_count_o    (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic outcome_t apply_command(command_e cmd, logic [OperandBits-1:0] opnd);
    outcome_t res;
    res.value  = '0;
    res.status = STATUS_DONE;
    res.met    = 1'b1;
    case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held >= Capacity) begin
          res.status = STATUS_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          store_mem[front_pos] = opnd[ValueBits-1:0];
          front_pos = (front_pos + 1) % Capacity;
          held++;
        end else begin
          back_pos = (back_pos + Capacity - 1) % Capacity;
          store_mem[back_pos] = opnd[ValueBits-1:0];
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          res.value  = EmptyMark;
          res.status = STATUS_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          front_pos = (front_pos + Capacity - 1) % Capacity;
          res.value = OperandBits'(store_mem[front_pos]);
          held--;
        end else begin
          res.value = OperandBits'(store_mem[back_pos]);
          back_pos = (back_pos + 1) % Capacity;
          held--;
        end
        res.met = (res.value == opnd);
      end
    endcase
    res.count = held[CountBits-1:0];
    return res;
  endfunction

  // Value the next pop at this end would return
  function automatic logic [OperandBits-1:0] end_value(command_e cmd);
    if (held == 0) return EmptyMark;
    if (cmd == CMD_POP_FRONT)
      return OperandBits'(store_mem[(front_pos + Capacity - 1) % Capacity]);
    return OperandBits'(store_mem[back_pos]);
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_command(input command_e cmd, input logic [OperandBits-1:0] opnd);
    int unsigned gap;
    if (sent_count % 64 == 0) gaps_on = $urandom_range(0, 1);
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    operand_i <= opnd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_outcomes.push_back(apply_command(cmd, opnd));
    sent_count++;
  endtask

  function automatic logic [OperandBits-1:0] push_operand();
    case ($urandom_range(0, 15))
      0:       return EmptyMark;
      1:       return '0;
      2:       return MaxValue;
      default: return $urandom() & MaxValue;
    endcase
  endfunction

  function automatic logic [OperandBits-1:0] pop_operand(command_e cmd);
    case ($urandom_range(0, 9))
      8:       return EmptyMark;
      9:       return $urandom() & MaxValue;
      default: return end_value(cmd);
    endcase
  endfunction

  task automatic send_random(input int unsigned push_pct);
    command_e cmd;
    if ($urandom_range(0, 99) < push_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      send_command(cmd, push_operand());
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      send_command(cmd, pop_operand(cmd));
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no command outstanding");
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (popped_value_o !== exp_res.value)
          report_mismatch($sformatf("popped_value got %h exp %h",
                                    popped_value_o, exp_res.value));
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status got %0d exp %0d", status_o, exp_res.status));
        if (expectation_met_o !== exp_res.met)
          report_mismatch($sformatf("expectation_met got %b exp %b",
                                    expectation_met_o, exp_res.met));
        if (entry_count_o !== exp_res.count)
          report_mismatch($sformatf("entry_count got %0d exp %0d",
                                    entry_count_o, exp_res.count));
      end
    end
  end

  task automatic test_empty_pops();
    send_command(CMD_POP_FRONT, EmptyMark);
    send_command(CMD_POP_BACK, EmptyMark);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, MaxValue);
  endtask

  task automatic test_end_values();
    send_command(CMD_PUSH_FRONT, MaxValue);
    send_command(CMD_PUSH_BACK, '0);
    // all-ones operand keeps only the low value bits
    send_command(CMD_PUSH_FRONT, EmptyMark);
    send_command(CMD_PUSH_BACK, 32'd1);
    send_command(CMD_POP_BACK, 32'd1);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, MaxValue);
    send_command(CMD_POP_FRONT, EmptyMark);
    send_command(CMD_PUSH_BACK, 32'd12345);
    send_command(CMD_POP_FRONT, 32'd12345);
    send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFE);
    send_command(CMD_POP_BACK, 32'h7FFF_FFFE);
  endtask

  task automatic test_random_mix();
    repeat (150) send_random(50);
  endtask

  // fill to the brim, hammer the full store, then drain part of it
  task automatic test_fill_and_drain();
    while (held < Capacity) send_random(100);
    repeat (8) send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                            push_operand());
    repeat (40) send_random(60);
    repeat (150) send_random(10);
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    command_i   = CMD_PUSH_FRONT;
    operand_i   = '0;
    front_pos   = 0;
    back_pos    = 0;
    held        = 0;
    error_count = 0;
    cycle_count = 0;
    sent_count  = 0;
    gaps_on     = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pops();
    test_end_values();
    test_random_mix();
    test_fill_and_drain();
    test_random_mix();

    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: ring_buffer_deque.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_ram.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque.sv
test/tb_ring_buffer_deque.sv
